// ===== src/vgapgc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vgapgc_pkg;

	localparam int PLANES          = 4;
	localparam int PLANE_BYTES_DEF = 65536;
	localparam int OFFSET_W        = 16;
	localparam int BYTE_W          = 8;
	localparam int WORD_W          = PLANES * BYTE_W;
	localparam int PADDR_W         = 5;
	localparam int PDATA_W         = 32;

	localparam logic [OFFSET_W-1:0] LIMIT_VGA  = 16'd38400;
	localparam logic [OFFSET_W-1:0] LIMIT_SVGA = 16'd60000;

	typedef enum logic [1:0] {
		LF_REPLACE = 2'd0,
		LF_AND     = 2'd1,
		LF_OR      = 2'd2,
		LF_XOR     = 2'd3
	} logic_fn_t;

	typedef enum logic [1:0] {
		WM_0 = 2'd0,
		WM_1 = 2'd1,
		WM_2 = 2'd2,
		WM_3 = 2'd3
	} wmode_t;

	typedef enum logic [2:0] {
		REG_SET_RESET        = 3'd0,
		REG_ENABLE_SET_RESET = 3'd1,
		REG_ROTATE_COUNT     = 3'd2,
		REG_LOGIC_FUNCTION   = 3'd3,
		REG_READ_PLANE       = 3'd4,
		REG_WRITE_MODE       = 3'd5,
		REG_BIT_MASK         = 3'd6,
		REG_SVGA_MODE        = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [PLANES-1:0] set_reset;
		logic [PLANES-1:0] enable_set_reset;
		logic [2:0]        rotate_count;
		logic_fn_t         logic_function;
		logic [1:0]        read_plane;
		wmode_t            write_mode;
		logic [BYTE_W-1:0] bit_mask;
		logic              svga_mode;
	} cfg_t;

endpackage
`default_nettype wire

// ===== src/vgapgc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vgapgc_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vgapgc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [vgapgc_pkg::PDATA_W-1:0] pwdata,
	output logic      [vgapgc_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	output vgapgc_pkg::cfg_t                  cfg
);
	import vgapgc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_reset        <= '0;
			cfg_q.enable_set_reset <= '0;
			cfg_q.rotate_count     <= '0;
			cfg_q.logic_function   <= LF_REPLACE;
			cfg_q.read_plane       <= '0;
			cfg_q.write_mode       <= WM_0;
			cfg_q.bit_mask         <= '1;
			cfg_q.svga_mode        <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SET_RESET:        cfg_q.set_reset        <= pwdata[PLANES-1:0];
				REG_ENABLE_SET_RESET: cfg_q.enable_set_reset <= pwdata[PLANES-1:0];
				REG_ROTATE_COUNT:     cfg_q.rotate_count     <= pwdata[2:0];
				REG_LOGIC_FUNCTION:   cfg_q.logic_function   <= logic_fn_t'(pwdata[1:0]);
				REG_READ_PLANE:       cfg_q.read_plane       <= pwdata[1:0];
				REG_WRITE_MODE:       cfg_q.write_mode       <= wmode_t'(pwdata[1:0]);
				REG_BIT_MASK:         cfg_q.bit_mask         <= pwdata[BYTE_W-1:0];
				REG_SVGA_MODE:        cfg_q.svga_mode        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SET_RESET:        prdata = PDATA_W'(cfg_q.set_reset);
			REG_ENABLE_SET_RESET: prdata = PDATA_W'(cfg_q.enable_set_reset);
			REG_ROTATE_COUNT:     prdata = PDATA_W'(cfg_q.rotate_count);
			REG_LOGIC_FUNCTION:   prdata = PDATA_W'(cfg_q.logic_function);
			REG_READ_PLANE:       prdata = PDATA_W'(cfg_q.read_plane);
			REG_WRITE_MODE:       prdata = PDATA_W'(cfg_q.write_mode);
			REG_BIT_MASK:         prdata = PDATA_W'(cfg_q.bit_mask);
			REG_SVGA_MODE:        prdata = PDATA_W'(cfg_q.svga_mode);
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/vgapgc_plane_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vgapgc_plane_ram #(
	parameter int DEPTH = vgapgc_pkg::PLANE_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [vgapgc_pkg::WORD_W-1:0] wdata,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 raddr,
	output logic      [vgapgc_pkg::WORD_W-1:0] rdata
);
	import vgapgc_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/vgapgc_write_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vgapgc_write_unit (
	input  wire vgapgc_pkg::cfg_t              cfg,
	input  wire logic [vgapgc_pkg::WORD_W-1:0] latches,
	input  wire logic [vgapgc_pkg::BYTE_W-1:0] cpu_data,
	output logic      [vgapgc_pkg::WORD_W-1:0] new_word
);
	import vgapgc_pkg::*;

	logic [2*BYTE_W-1:0] dbl;
	logic [BYTE_W-1:0]   rdata;
	logic [BYTE_W-1:0]   mask;

	assign dbl   = {cpu_data, cpu_data} >> cfg.rotate_count;
	assign rdata = (cfg.write_mode == WM_2) ? cpu_data : dbl[BYTE_W-1:0];
	assign mask  = (cfg.write_mode == WM_3) ? (cfg.bit_mask & rdata) : cfg.bit_mask;

	for (genvar p = 0; p < PLANES; p++) begin : g_plane
		logic [BYTE_W-1:0] latch;
		logic [BYTE_W-1:0] src;
		logic [BYTE_W-1:0] val;

		assign latch = latches[p*BYTE_W +: BYTE_W];

		always_comb begin
			priority if (cfg.write_mode == WM_2) begin
				src = {BYTE_W{cpu_data[p]}};
			end else if (cfg.write_mode == WM_3 || cfg.enable_set_reset[p]) begin
				src = {BYTE_W{cfg.set_reset[p]}};
			end else begin
				src = rdata;
			end
		end

		always_comb begin
			unique case (cfg.logic_function)
				LF_AND:  val = src & latch;
				LF_OR:   val = src | latch;
				LF_XOR:  val = src ^ latch;
				default: val = src;
			endcase
		end

		assign new_word[p*BYTE_W +: BYTE_W] = (cfg.write_mode == WM_1) ? latch :
			((val & mask) | (latch & ~mask));
	end

endmodule
`default_nettype wire

// ===== src/vga_planar_graphics_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake                         payload
// request   in_valid / in_ready               cmd, offset, write_data
// result    out_valid / out_ready             read_data, dropped
// config    psel, penable, pwrite / pready    paddr, pwdata -> prdata
//
// Each request runs as the plane RAM read on acceptance, then the
// modify and write-back cycle through the same single-port-pair RAM.
// After reset a clearing pass writes zero to all PLANE_BYTES words, one per
// cycle; in_ready stays low until the clearing pass ends.
// A result that waits on out_ready holds the write-back cycle; in_ready
// returns once the result is registered.
module vga_planar_graphics_controller #(
	parameter int PLANE_BYTES = vgapgc_pkg::PLANE_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            cmd,
	input  wire logic [vgapgc_pkg::OFFSET_W-1:0] offset,
	input  wire logic [vgapgc_pkg::BYTE_W-1:0]   write_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [vgapgc_pkg::BYTE_W-1:0]   read_data,
	output logic                                 dropped,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vgapgc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [vgapgc_pkg::PDATA_W-1:0]  pwdata,
	output logic      [vgapgc_pkg::PDATA_W-1:0]  prdata,
	output logic                                 pready
);
	import vgapgc_pkg::*;

	localparam int AW = $clog2(PLANE_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PLANE_BYTES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_MOD   = 3'b100
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_addr_q;
	cfg_t              cfg;
	logic              accept;
	logic              in_area;
	logic [OFFSET_W-1:0] limit;
	logic              go;

	logic              cmd_s1;
	logic              drop_s1;
	logic [AW-1:0]     addr_s1;
	logic [BYTE_W-1:0] wdata_s1;

	logic [WORD_W-1:0] latches;
	logic [WORD_W-1:0] new_word;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;

	logic              out_valid_q;
	logic [BYTE_W-1:0] read_data_q;
	logic              dropped_q;

	vgapgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign limit    = cfg.svga_mode ? LIMIT_SVGA : LIMIT_VGA;
	assign in_area  = (offset < limit) && (32'(offset) < 32'(PLANE_BYTES));
	assign go       = (state_q == ST_MOD) && (!out_valid_q || out_ready);

	vgapgc_write_unit u_write (
		.cfg      (cfg),
		.latches  (latches),
		.cpu_data (wdata_s1),
		.new_word (new_word)
	);

	always_comb begin
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_MOD: begin
				ram_we    = go & cmd_s1 & ~drop_s1;
				ram_waddr = addr_s1;
				ram_wdata = new_word;
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = addr_s1;
				ram_wdata = new_word;
			end
		endcase
	end

	vgapgc_plane_ram #(
		.DEPTH (PLANE_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (offset[AW-1:0]),
		.rdata (latches)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold request fields for the write-back cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			drop_s1  <= ~in_area;
			addr_s1  <= offset[AW-1:0];
			wdata_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dropped_q   <= drop_s1;
			read_data_q <= (drop_s1 || cmd_s1) ? '0 :
				latches[cfg.read_plane*BYTE_W +: BYTE_W];
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign dropped   = dropped_q;

endmodule
`default_nettype wire

// ===== src/vgapgc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vgapgc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [vgapgc_pkg::BYTE_W-1:0] read_data,
	input wire logic                          dropped
);
	import vgapgc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(dropped))
		else $error("result changed while stalled");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> read_data == '0)
		else $error("dropped request returned data");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while one is in flight");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a request two cycles before");

endmodule

bind vga_planar_graphics_controller vgapgc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data),
	.dropped   (dropped)
);
`default_nettype wire
